// ----- rtl/core/pkl_pkg.sv -----
// Shared types, constants and the CRC function of the packet loader.
`default_nettype none
package pkl_pkg;

    localparam int MEM_WORDS = 16384;
    localparam int PTR_W     = $clog2(MEM_WORDS + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [31:0] MAGIC_WORD = 32'h5a5a5a5a;
    localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
    localparam logic [31:0] TYPE_START = 32'h000000ee;
    localparam logic [31:0] TYPE_DATA  = 32'h00000001;
    localparam logic [31:0] TYPE_RUN   = 32'h000000aa;
    localparam logic [31:0] CODE_ACK   = 32'h00000002;
    localparam logic [31:0] CODE_FAIL  = 32'h00000003;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    // One entry between front and back: an optional memory write, an
    // optional reply packet and an optional start of execution.
    typedef struct packed {
        logic        wr;
        logic [31:0] data;
        logic [15:0] addr;
        logic        reply;
        logic        ack;
        logic        run;
    } cmd_t;

    // Bitwise update, low byte first, left shift on a set bit 0.
    function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                              input logic [31:0] w);
        logic [31:0] c;
        c = crc_in;
        for (int b = 0; b < 4; b++)
        begin
            c = c ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++)
            begin
                if (c[0])
                begin
                    c = {c[30:0], 1'b0} ^ CRC_POLY;
                end
                else
                begin
                    c = {c[30:0], 1'b0};
                end
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/packet_loader_with_crc_check_core.sv -----
// Top level of the packet loader: front end, command queue and back end.
// A result-causing word passes the queue, then the back end's command and output registers.
// Throughput: one input word per cycle while the queue has room; the back end sends one
// result per cycle while out_ready is high; a reply is four words (five after a write).
// The 4-entry command queue absorbs those bursts; rx_ready drops only when it is full.
// Reset: rst_n clears all control state asynchronously; load_base resets to 0.
`default_nettype none
module packet_loader_with_crc_check_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    input  wire logic         rx_valid,
    output logic              rx_ready,
    input  wire logic [31:0]  rx_word,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        kind,
    output logic [31:0]       word,
    output logic [15:0]       addr,
    output logic              last
);
    import pkl_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_ready;
    logic q_valid;
    cmd_t q_cmd;
    logic pop;

    pkl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_word     (rx_word),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_ready     (q_ready)
    );

    pkl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .in_ready (q_ready),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    pkl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .word      (word),
        .addr      (addr),
        .last      (last)
    );

endmodule
`default_nettype wire

// ----- rtl/core/pkl_front.sv -----
// Front end: header framing, CRC check, load pointer and command issue.
`default_nettype none
module pkl_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    input  wire logic         rx_valid,
    output logic              rx_ready,
    input  wire logic [31:0]  rx_word,
    output logic              push,
    output pkl_pkg::cmd_t     push_cmd,
    input  wire logic         q_ready
);
    import pkl_pkg::*;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [15:0]      load_base_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       hidx_reg, hidx_next;
    logic             magic_ok_reg, magic_ok_next;
    logic             is_start_reg, is_start_next;
    logic             is_data_reg, is_data_next;
    logic             is_run_reg, is_run_next;
    logic [31:0]      length_reg, length_next;
    logic [31:0]      exp_crc_reg, exp_crc_next;
    logic [31:0]      crc_reg, crc_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    logic             accept;
    logic [31:0]      crc_upd;
    logic [PTR_W-1:0] count_inc;
    logic [PTR_W-1:0] cap;
    logic [15:0]      wr_addr;
    cmd_t             cmd;

    assign rx_ready  = q_ready;
    assign accept    = rx_valid && q_ready;
    assign crc_upd   = crc_word(crc_reg, rx_word);
    assign count_inc = count_reg + 1'b1;
    assign cap       = PTR_W'(MEM_WORDS) - ptr_reg;
    assign wr_addr   = load_base_reg + 16'(ptr_reg) + 16'(count_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        magic_ok_next = magic_ok_reg;
        is_start_next = is_start_reg;
        is_data_next  = is_data_reg;
        is_run_next   = is_run_reg;
        length_next   = length_reg;
        exp_crc_next  = exp_crc_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        cmd           = '0;

        if (accept && phase_reg == PH_DATA)
        begin
            cmd.wr     = 1'b1;
            cmd.data   = rx_word;
            cmd.addr   = wr_addr;
            crc_next   = crc_upd;
            count_next = count_inc;
            if (count_inc >= length_reg[PTR_W-1:0])
            begin
                cmd.reply  = 1'b1;
                cmd.ack    = (crc_upd == exp_crc_reg);
                phase_next = PH_HEADER;
                if (crc_upd == exp_crc_reg)
                begin
                    ptr_next = ptr_reg + length_reg[PTR_W-1:0];
                end
            end
        end
        else if (accept && phase_reg != PH_DONE)
        begin
            case (hidx_reg)
                2'd0: magic_ok_next = (rx_word == MAGIC_WORD);
                2'd1:
                begin
                    is_start_next = (rx_word == TYPE_START);
                    is_data_next  = (rx_word == TYPE_DATA);
                    is_run_next   = (rx_word == TYPE_RUN);
                end
                2'd2: length_next = rx_word;
                default: exp_crc_next = rx_word;
            endcase
            hidx_next = hidx_reg + 1'b1;
            // Fourth header word: act on the complete header.
            if (hidx_reg == 2'd3 && magic_ok_reg)
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (is_start_reg)
                    begin
                        cmd.reply  = 1'b1;
                        cmd.ack    = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
                else if (is_data_reg)
                begin
                    crc_next   = '0;
                    count_next = '0;
                    if (length_reg > {{(32-PTR_W){1'b0}}, cap})
                    begin
                        cmd.reply = 1'b1;
                    end
                    else if (length_reg == '0)
                    begin
                        cmd.reply = 1'b1;
                        cmd.ack   = (rx_word == '0);
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else if (is_run_reg)
                begin
                    cmd.run    = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    cmd.reply = 1'b1;
                end
            end
        end
    end

    assign push     = accept && (cmd.wr || cmd.reply || cmd.run);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg <= '0;
            phase_reg     <= PH_WAIT;
            hidx_reg      <= '0;
            magic_ok_reg  <= 1'b0;
            is_start_reg  <= 1'b0;
            is_data_reg   <= 1'b0;
            is_run_reg    <= 1'b0;
            length_reg    <= '0;
            exp_crc_reg   <= '0;
            crc_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                load_base_reg <= cfg_wr_data;
            end
            phase_reg    <= phase_next;
            hidx_reg     <= hidx_next;
            magic_ok_reg <= magic_ok_next;
            is_start_reg <= is_start_next;
            is_data_reg  <= is_data_next;
            is_run_reg   <= is_run_next;
            length_reg   <= length_next;
            exp_crc_reg  <= exp_crc_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
        end
    end

`ifndef SYNTH
    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> {{(32-PTR_W){1'b0}}, count_reg} < length_reg)
        else $error("data count reached packet length in data phase");
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(MEM_WORDS))
        else $error("load pointer past memory capacity");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/pkl_queue.sv -----
// Command queue between front end and back end.
`default_nettype none
module pkl_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  pkl_pkg::cmd_t      push_cmd,
    output logic               in_ready,
    output logic               q_valid,
    output pkl_pkg::cmd_t      q_cmd,
    input  wire logic          pop
);
    import pkl_pkg::*;

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg;
    logic [Q_AW-1:0] rptr_reg;
    logic [Q_AW:0]   cnt_reg;

    assign in_ready = (cnt_reg != (Q_AW+1)'(Q_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> in_ready)
        else $error("push into full command queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty command queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/pkl_back.sv -----
// Back end: expands queued commands into result words on the output channel.
`default_nettype none
module pkl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  pkl_pkg::cmd_t      q_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         kind,
    output logic [31:0]        word,
    output logic [15:0]        addr,
    output logic               last
);
    import pkl_pkg::*;

    // Step codes: write, four reply words, start execution.
    localparam logic [2:0] ST_WRITE = 3'd0;
    localparam logic [2:0] ST_REP0  = 3'd1;
    localparam logic [2:0] ST_REP1  = 3'd2;
    localparam logic [2:0] ST_REP2  = 3'd3;
    localparam logic [2:0] ST_REP3  = 3'd4;
    localparam logic [2:0] ST_RUN   = 3'd5;

    cmd_t        cmd_reg;
    logic        busy_reg;
    logic [2:0]  step_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [31:0] word_reg;
    logic [15:0] addr_reg;
    logic        last_reg;

    logic        load;
    logic        done_now;
    logic [1:0]  cur_kind;
    logic [31:0] cur_word;
    logic [15:0] cur_addr;
    logic        cur_last;
    logic [2:0]  first_step;

    always_comb
    begin
        cur_kind = KIND_REPLY;
        cur_word = '0;
        cur_addr = '0;
        cur_last = 1'b0;
        case (step_reg)
            ST_WRITE:
            begin
                cur_kind = KIND_WRITE;
                cur_word = cmd_reg.data;
                cur_addr = cmd_reg.addr;
                cur_last = !cmd_reg.reply;
            end
            ST_REP0: cur_word = MAGIC_WORD;
            ST_REP1: cur_word = cmd_reg.ack ? CODE_ACK : CODE_FAIL;
            ST_REP2: cur_word = '0;
            ST_REP3: cur_last = 1'b1;
            ST_RUN:
            begin
                cur_kind = KIND_RUN;
                cur_last = 1'b1;
            end
            default: cur_last = 1'b1;
        endcase
    end

    always_comb
    begin
        if (q_cmd.wr)
        begin
            first_step = ST_WRITE;
        end
        else if (q_cmd.reply)
        begin
            first_step = ST_REP0;
        end
        else
        begin
            first_step = ST_RUN;
        end
    end

    assign load     = busy_reg && (!valid_reg || out_ready);
    assign done_now = load && cur_last;
    assign pop      = q_valid && (!busy_reg || done_now);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load)
        begin
            kind_reg <= cur_kind;
            word_reg <= cur_word;
            addr_reg <= cur_addr;
            last_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= ST_WRITE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= first_step;
            end
            else
            begin
                if (done_now)
                begin
                    busy_reg <= 1'b0;
                end
                if (load)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign word      = word_reg;
    assign addr      = addr_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == ST_WRITE |-> cmd_reg.wr)
        else $error("write step without a write command");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= ST_RUN)
        else $error("back end step out of range");
`endif

endmodule
`default_nettype wire
